[rtl/bec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_pkg
// Shared types, constants and helper functions for the Bezier envelope
// compressor: register map, micro-op codes, step table and saturation.
// ----------------------------------------------------------------------------
package bec_pkg;

    // default parameter values
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 28;

    // internal signal format: signed, 24 fraction bits
    localparam int IFRAC = 24;
    localparam int XW    = 26;   // sample in internal format

    // shared multiplier
    localparam int OPND_W = 33;
    localparam int PROD_W = 2 * OPND_W;
    localparam int WIDE_W = PROD_W + 2;

    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(64'sd2147483647);
    localparam logic signed [WIDE_W-1:0] SAT_LO = ~SAT_HI;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESH_GAIN   = 3'd0,
        REG_INV_THRESH    = 3'd1,
        REG_CEILING_SCALE = 3'd2,
        REG_PERIOD_STEPS  = 3'd3,
        REG_STEP_FRACTION = 3'd4,
        REG_X_STEP        = 3'd5,
        REG_RELEASE_STEP  = 3'd6,
        REG_DRY_MIX       = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [30:0] thresh_gain;
        logic [29:0] inv_thresh;
        logic [29:0] ceiling_scale;
        logic [19:0] period_steps;
        logic [31:0] step_fraction;
        logic [31:0] x_step;
        logic [31:0] release_step;
        logic [28:0] dry_mix;
    } cfg_t;

    localparam logic [30:0] THRESH_GAIN_RST   = 31'd542910710;
    localparam logic [29:0] INV_THRESH_RST    = 30'd132725000;
    localparam logic [29:0] CEILING_SCALE_RST = 30'd235928000;
    localparam logic [19:0] PERIOD_STEPS_RST  = 20'd1000;
    localparam logic [31:0] STEP_FRACTION_RST = 32'd4294967;
    localparam logic [31:0] X_STEP_RST        = 32'd4290677;
    localparam logic [31:0] RELEASE_STEP_RST  = 32'd4295;
    localparam logic [28:0] DRY_MIX_RST       = 29'd0;

    // multiplier operations; the name tells where the product goes
    typedef enum logic [4:0] {
        OP_NONE,
        OP_T,      // x * gain
        OP_CEIL,   // ceiling_scale * gain
        OP_S,      // t * inv_thresh
        OP_T1A,    // x * dry
        OP_T2A,    // s * (1 - dry)
        OP_ACC,    // floor * step_fraction
        OP_WA,     // X * X
        OP_WC,     // u * u
        OP_WB,     // 2 * u * X
        OP_LC,     // oldest * wc
        OP_LB,     // middle * wb
        OP_LA,     // newest * wa
        OP_F1,     // gain * (1 - dry)
        OP_T2B,    // t2 * gain
        OP_T1B,    // t1 * f1
        OP_T2C     // t2 * thresh_gain
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_FLOOR,
        ACT_GAIN
    } act_t;

    typedef struct packed {
        op_t  iss;
        act_t act;
    } uop_t;

    typedef struct packed {
        op_t  iss;      // operation issued to the multiplier this cycle
        op_t  wb;       // operation whose product is written back this cycle
        act_t act;      // non-multiply update this cycle
        logic accept;   // input transaction this cycle
        logic finish;   // result loaded into the output register
    } ctl_t;

    localparam int               STEP_W    = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd20;

    // Step table. A product issued at step k is written back at k+1, so a
    // dependent operation is issued at k+2 or later.
    function automatic uop_t step_uop(input logic [STEP_W-1:0] step);
        uop_t u;
        u.iss = OP_NONE;
        u.act = ACT_NONE;
        case (step)
            5'd0:  u.iss = OP_T;
            5'd1:  u.iss = OP_CEIL;
            5'd2:  u.iss = OP_S;
            5'd3:  u.iss = OP_T1A;
            5'd4:
            begin
                u.iss = OP_T2A;
                u.act = ACT_FLOOR;
            end
            5'd5:  u.iss = OP_ACC;
            5'd7:  u.iss = OP_WA;
            5'd8:  u.iss = OP_WC;
            5'd9:  u.iss = OP_WB;
            5'd10: u.iss = OP_LC;
            5'd11: u.iss = OP_LB;
            5'd12: u.iss = OP_LA;
            5'd14: u.act = ACT_GAIN;
            5'd15: u.iss = OP_F1;
            5'd16: u.iss = OP_T2B;
            5'd17: u.iss = OP_T1B;
            5'd18: u.iss = OP_T2C;
            default: ;
        endcase
        return u;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = 32'sh7FFFFFFF;
        else if (v < SAT_LO)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/bec_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_channels
// Valid/ready stream interfaces for the sample and result channels.
// ----------------------------------------------------------------------------
interface bec_in_if
    import bec_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bec_out_if
    import bec_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/bec_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_cfg_regs
// Configuration register file, write-only, indexed by register number.
// ----------------------------------------------------------------------------
module bec_cfg_regs
    import bec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh_gain   <= THRESH_GAIN_RST;
            cfg_reg.inv_thresh    <= INV_THRESH_RST;
            cfg_reg.ceiling_scale <= CEILING_SCALE_RST;
            cfg_reg.period_steps  <= PERIOD_STEPS_RST;
            cfg_reg.step_fraction <= STEP_FRACTION_RST;
            cfg_reg.x_step        <= X_STEP_RST;
            cfg_reg.release_step  <= RELEASE_STEP_RST;
            cfg_reg.dry_mix       <= DRY_MIX_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_THRESH_GAIN:   cfg_reg.thresh_gain   <= cfg_data[30:0];
                REG_INV_THRESH:    cfg_reg.inv_thresh    <= cfg_data[29:0];
                REG_CEILING_SCALE: cfg_reg.ceiling_scale <= cfg_data[29:0];
                REG_PERIOD_STEPS:  cfg_reg.period_steps  <= cfg_data[19:0];
                REG_STEP_FRACTION: cfg_reg.step_fraction <= cfg_data;
                REG_X_STEP:        cfg_reg.x_step        <= cfg_data;
                REG_RELEASE_STEP:  cfg_reg.release_step  <= cfg_data;
                REG_DRY_MIX:       cfg_reg.dry_mix       <= cfg_data[28:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/bec_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module bec_mul
    import bec_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [OPND_W-1:0] a,
    input  logic signed [OPND_W-1:0] b,
    output logic signed [PROD_W-1:0] p
);

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

[rtl/bec_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_seq
// Sequencer: handshakes, step counter, micro-op issue and write-back.
// ----------------------------------------------------------------------------
module bec_seq
    import bec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output ctl_t ctl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    op_t               wb_reg;
    logic              out_valid_reg, out_valid_next;
    uop_t              uop;
    logic              running;
    logic              slot_free;

    assign uop       = step_uop(step_reg);
    assign running   = (state_reg == ST_RUN);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        ctl.iss    = running ? uop.iss : OP_NONE;
        ctl.act    = running ? uop.act : ACT_NONE;
        ctl.wb     = wb_reg;
        ctl.accept = (state_reg == ST_IDLE) && in_valid;
        ctl.finish = running && (step_reg == LAST_STEP) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (step_reg != LAST_STEP)
                    step_next = step_reg + STEP_W'(1);
                else if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output slot: loaded on finish, emptied when the result is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            wb_reg        <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            wb_reg        <= ctl.iss;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/bec_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_dp
// Datapath: operand selection, product write-back, compressor state and
// output formatting.
// ----------------------------------------------------------------------------
module bec_dp
    import bec_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctl_t                          ctl,
    input  cfg_t                          cfg,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic signed [PROD_W-1:0]      p,
    output logic signed [OPND_W-1:0]      mul_a,
    output logic signed [OPND_W-1:0]      mul_b,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);

    // sample <-> internal format shifts
    localparam int XSH_R = (SAMPLE_BITS > IFRAC + 1) ? SAMPLE_BITS - IFRAC - 1 : 0;
    localparam int XSH_L = (SAMPLE_BITS < IFRAC + 1) ? IFRAC + 1 - SAMPLE_BITS : 0;
    localparam int XE_W  = SAMPLE_BITS + XSH_L + 1;
    localparam int YW    = 32 + XSH_R + 1;

    localparam int SH_CEIL = 2 * COEF_FRAC_BITS - IFRAC;
    localparam int GSH_L   = (COEF_FRAC_BITS > IFRAC) ? COEF_FRAC_BITS - IFRAC : 0;
    localparam int GSH_R   = (COEF_FRAC_BITS < IFRAC) ? IFRAC - COEF_FRAC_BITS : 0;

    localparam logic signed [31:0]     ONE_CF   = 32'sd1 <<< COEF_FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] ONE_CF_W = WIDE_W'(ONE_CF);
    localparam logic signed [34:0]     LEV_ONE  = 35'sd1 <<< IFRAC;
    localparam logic signed [41:0]     ACC_HI   = (42'sd1 <<< 39) - 42'sd1;
    localparam logic signed [41:0]     ACC_LO   = ~ACC_HI;
    localparam logic signed [YW-1:0]   Y_HI     = (YW'(1) <<< (SAMPLE_BITS - 1)) - YW'(1);
    localparam logic signed [YW-1:0]   Y_LO     = ~Y_HI;

    // compressor state
    logic        [31:0] gain_reg;
    logic signed [31:0] floor_reg;
    logic signed [39:0] acc_reg;
    logic        [19:0] count_reg;
    logic        [31:0] xpos_reg;
    logic signed [39:0] hist_new_reg, hist_mid_reg, hist_old_reg;

    // per-sample working registers
    logic signed [XW-1:0] x_reg;
    logic signed [31:0]   t_reg, s_reg, ceil_reg, t1_reg, t2_reg, f1_reg;
    logic        [30:0]   wc_reg, wb_reg, wa_reg, u_reg;
    logic signed [31:0]   oned_reg;
    logic signed [34:0]   lev_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    // input conversion
    logic signed [XE_W-1:0] x_ext, x_sh;
    logic signed [XW-1:0]   x_conv;

    assign x_ext  = XE_W'(sample_in);
    assign x_sh   = (x_ext >>> XSH_R) <<< XSH_L;
    assign x_conv = x_sh[XW-1:0];

    // history entries in Q.24
    logic signed [31:0] h_new, h_mid, h_old;
    logic        [29:0] x30;

    assign h_new = hist_new_reg[39:8];
    assign h_mid = hist_mid_reg[39:8];
    assign h_old = hist_old_reg[39:8];
    assign x30   = xpos_reg[31:2];

    // operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.iss)
            OP_T:
            begin
                mul_a = OPND_W'(x_reg);
                mul_b = {1'b0, gain_reg};
            end
            OP_CEIL:
            begin
                mul_a = {3'b0, cfg.ceiling_scale};
                mul_b = {1'b0, gain_reg};
            end
            OP_S:
            begin
                mul_a = OPND_W'(t_reg);
                mul_b = {3'b0, cfg.inv_thresh};
            end
            OP_T1A:
            begin
                mul_a = OPND_W'(x_reg);
                mul_b = {4'b0, cfg.dry_mix};
            end
            OP_T2A:
            begin
                mul_a = OPND_W'(s_reg);
                mul_b = OPND_W'(oned_reg);
            end
            OP_ACC:
            begin
                mul_a = OPND_W'(floor_reg);
                mul_b = {1'b0, cfg.step_fraction};
            end
            OP_WA:
            begin
                mul_a = {3'b0, x30};
                mul_b = {3'b0, x30};
            end
            OP_WC:
            begin
                mul_a = {2'b0, u_reg};
                mul_b = {2'b0, u_reg};
            end
            OP_WB:
            begin
                mul_a = {2'b0, u_reg};
                mul_b = {3'b0, x30};
            end
            OP_LC:
            begin
                mul_a = OPND_W'(h_old);
                mul_b = {2'b0, wc_reg};
            end
            OP_LB:
            begin
                mul_a = OPND_W'(h_mid);
                mul_b = {2'b0, wb_reg};
            end
            OP_LA:
            begin
                mul_a = OPND_W'(h_new);
                mul_b = {2'b0, wa_reg};
            end
            OP_F1:
            begin
                mul_a = {1'b0, gain_reg};
                mul_b = OPND_W'(oned_reg);
            end
            OP_T2B:
            begin
                mul_a = OPND_W'(t2_reg);
                mul_b = {1'b0, gain_reg};
            end
            OP_T1B:
            begin
                mul_a = OPND_W'(t1_reg);
                mul_b = OPND_W'(f1_reg);
            end
            OP_T2C:
            begin
                mul_a = OPND_W'(t2_reg);
                mul_b = {2'b0, cfg.thresh_gain};
            end
            default: ;
        endcase
    end

    // rescaled products (floor)
    logic signed [PROD_W-1:0] p_cf, p_ceil, p_24, p_29, p_30;

    assign p_cf   = p >>> COEF_FRAC_BITS;
    assign p_ceil = p >>> SH_CEIL;
    assign p_24   = p >>> IFRAC;
    assign p_29   = p >>> 29;
    assign p_30   = p >>> 30;

    // accumulator, counter and position update
    logic signed [41:0] acc_sum;
    logic signed [39:0] acc_sat;
    logic        [20:0] count_inc;
    logic               wrap;
    logic        [32:0] xpos_sum;
    logic        [31:0] xpos_adv;

    assign acc_sum   = 42'(acc_reg) + 42'(p_24);
    assign acc_sat   = (acc_sum > ACC_HI) ? ACC_HI[39:0] :
                       (acc_sum < ACC_LO) ? ACC_LO[39:0] : acc_sum[39:0];
    assign count_inc = {1'b0, count_reg} + 21'd1;
    assign wrap      = count_inc > {1'b0, cfg.period_steps};
    assign xpos_sum  = {1'b0, xpos_reg} + {1'b0, cfg.x_step};
    assign xpos_adv  = xpos_sum[32] ? '1 : xpos_sum[31:0];

    // floor tracker
    logic signed [32:0] fl;
    logic signed [31:0] ctrl;
    logic signed [31:0] floor_next;

    assign fl         = 33'(floor_reg) - {9'b0, cfg.release_step[31:8]};
    assign ctrl       = (s_reg < ceil_reg) ? s_reg : ceil_reg;
    assign floor_next = (fl > 33'(ctrl)) ? fl[31:0] : ctrl;

    // new gain from the level
    logic signed [34:0] g24;
    logic        [43:0] g_ext, g_sh;
    logic        [31:0] gain_next;

    assign g24       = LEV_ONE - lev_reg;
    assign g_ext     = {9'b0, g24};
    assign g_sh      = (g_ext << GSH_L) >> GSH_R;
    assign gain_next = (lev_reg >= LEV_ONE) ? 32'd0 :
                       ((|g_sh[43:32]) ? '1 : g_sh[31:0]);

    // level: middle entry plus first weighted term
    logic signed [34:0] lev_first;
    logic signed [34:0] lev_add;

    assign lev_first = 35'(h_mid) + 35'(p_30);
    assign lev_add   = lev_reg + 35'(p_30);

    // output blend and formatting
    logic signed [32:0]     y_sum;
    logic signed [31:0]     y32;
    logic signed [YW-1:0]   y_ext;
    logic signed [YW-1:0]   y_clip;

    assign y_sum  = 33'(t1_reg) + 33'(t2_reg);
    assign y32    = sat32(WIDE_W'(y_sum));
    assign y_ext  = (YW'(y32) >>> XSH_L) <<< XSH_R;
    assign y_clip = (y_ext > Y_HI) ? Y_HI : ((y_ext < Y_LO) ? Y_LO : y_ext);

    // state that the model clears at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= '0;
            floor_reg    <= '0;
            acc_reg      <= '0;
            count_reg    <= '0;
            xpos_reg     <= '0;
            hist_new_reg <= '0;
            hist_mid_reg <= '0;
            hist_old_reg <= '0;
        end
        else
        begin
            if (ctl.act == ACT_FLOOR)
                floor_reg <= floor_next;
            if (ctl.act == ACT_GAIN)
                gain_reg <= gain_next;
            if (ctl.wb == OP_ACC)
            begin
                if (wrap)
                begin
                    count_reg    <= '0;
                    xpos_reg     <= '0;
                    hist_old_reg <= hist_mid_reg;
                    hist_mid_reg <= hist_new_reg;
                    hist_new_reg <= acc_sat;
                    acc_reg      <= '0;
                end
                else
                begin
                    count_reg <= count_inc[19:0];
                    xpos_reg  <= xpos_adv;
                    acc_reg   <= acc_sat;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        oned_reg <= ONE_CF - {3'b0, cfg.dry_mix};
        u_reg    <= (31'd1 << 30) - {1'b0, x30};
        if (ctl.accept)
            x_reg <= x_conv;
        if (ctl.finish)
            out_reg <= y_clip[SAMPLE_BITS-1:0];
        case (ctl.wb)
            OP_T:    t_reg    <= sat32(WIDE_W'(p_cf));
            OP_CEIL: ceil_reg <= sat32(WIDE_W'(p_ceil));
            OP_S:    s_reg    <= sat32(WIDE_W'(p_cf));
            OP_T1A:  t1_reg   <= sat32(WIDE_W'(p_cf));
            OP_T2A:  t2_reg   <= sat32(WIDE_W'(p_cf));
            OP_WA:   wa_reg   <= p_30[30:0];
            OP_WC:   wc_reg   <= p_30[30:0];
            OP_WB:   wb_reg   <= p_29[30:0];
            OP_LC:   lev_reg  <= lev_first;
            OP_LB:   lev_reg  <= lev_add;
            OP_LA:   lev_reg  <= lev_add;
            OP_F1:   f1_reg   <= sat32(ONE_CF_W - WIDE_W'(p_cf));
            OP_T2B:  t2_reg   <= sat32(WIDE_W'(p_cf));
            OP_T1B:  t1_reg   <= sat32(WIDE_W'(p_cf));
            OP_T2C:  t2_reg   <= sat32(WIDE_W'(p_cf));
            default: ;
        endcase
    end

    assign sample_out = out_reg;

endmodule

[rtl/bezier_envelope_compressor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_envelope_compressor
// Mono compressor whose gain follows a quadratic Bezier over a three-entry
// history of integrated envelope segments.
// ----------------------------------------------------------------------------
// Usage: one sample enters on sample_ch and one processed sample leaves on
// result_ch per transaction. Every multiply runs on a single shared 33x33
// multiplier under a 21-step sequencer (16 products, each written back in
// the cycle after its issue, plus floor, gain and output steps). The block
// is not ready while it works on a sample. A finished result sits in an
// output register; the next sample is accepted while it waits, and the
// sequencer holds on its last step only when the previous result has
// still not been taken. Coefficients are computed by software:
// thresh_gain, inv_thresh, ceiling_scale and dry_mix in unsigned
// Q(32-F).F with F = COEF_FRAC_BITS, step_fraction, x_step and
// release_step in Q0.32. Write registers only while idle.
// ----------------------------------------------------------------------------
module bezier_envelope_compressor
    import bec_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bec_in_if.sink                sample_ch,
    bec_out_if.source             result_ch
);

    cfg_t                     cfg;
    ctl_t                     ctl;
    logic signed [OPND_W-1:0] mul_a;
    logic signed [OPND_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     in_ready;
    logic                     out_valid;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    // register file, reset to the default coefficient set
    bec_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshakes and the step table
    bec_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result_ch.ready),
        .ctl       (ctl)
    );

    // the one multiplier; product registered before write-back
    bec_mul u_mul (
        .clk (clk),
        .en  (ctl.iss != OP_NONE),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // envelope state, Bezier level, gain and output blend
    bec_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cfg        (cfg),
        .sample_in  (sample_ch.sample_in),
        .p          (prod),
        .mul_a      (mul_a),
        .mul_b      (mul_b),
        .sample_out (sample_out)
    );

    assign sample_ch.ready      = in_ready;
    assign result_ch.valid      = out_valid;
    assign result_ch.sample_out = sample_out;

endmodule
